FILE: rtl/key_matrix_to_char_mapper_top_macros.svh
// assertion macros for the key matrix to character mapper
`ifndef KEY_MATRIX_TO_CHAR_MAPPER_TOP_MACROS_SVH
`define KEY_MATRIX_TO_CHAR_MAPPER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define KMCM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define KMCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/kmcm_pkg.sv
// shared types, codes and key tables of the key matrix to character mapper
`default_nettype none

package kmcm_pkg;

    // entry operation codes carried on tuser
    typedef enum logic [1:0] {
        OP_PRESS   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_END     = 2'd2
    } kmcm_op_t;

    // batch-end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } kmcm_state_t;

    // which map the lookup uses
    typedef struct packed {
        logic symbol;
        logic upper;
    } kmcm_mode_t;

    localparam logic [1:0] SYM_ROW   = 2'd1;
    localparam logic [3:0] SYM_COL   = 4'd10;
    localparam logic [1:0] SHIFT_ROW = 2'd2;
    localparam logic [3:0] SHIFT_COL = 4'd7;
    localparam logic [3:0] NUM_COLS  = 4'd11;

    // results per batch are capped at eight
    localparam int unsigned NF_W = 4;
    localparam logic [NF_W-1:0] MAX_RESULTS = 4'd8;

    typedef logic [6:0] kmcm_char_t;

    localparam kmcm_char_t MAP_LOWER [0:3][0:10] = '{
        '{7'h00, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70},
        '{7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h0A, 7'h00},
        '{7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h00, 7'h08, 7'h20, 7'h00},
        '{7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00}
    };

    localparam kmcm_char_t MAP_UPPER [0:3][0:10] = '{
        '{7'h00, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50},
        '{7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h0A, 7'h00},
        '{7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h00, 7'h08, 7'h20, 7'h00},
        '{7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00}
    };

    localparam kmcm_char_t MAP_SYMBOL [0:3][0:10] = '{
        '{7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30},
        '{7'h2E, 7'h2F, 7'h2B, 7'h2D, 7'h3D, 7'h3A, 7'h27, 7'h22, 7'h40, 7'h09, 7'h00},
        '{7'h5F, 7'h24, 7'h3B, 7'h3F, 7'h21, 7'h2C, 7'h2E, 7'h00, 7'h08, 7'h20, 7'h00},
        '{7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00}
    };

endpackage

`default_nettype wire

FILE: rtl/kmcm_keymap.sv
// key position to character lookup through the fixed maps
`default_nettype none

module kmcm_keymap import kmcm_pkg::*; (
    input  wire logic [1:0]  key_row,
    input  wire logic [3:0]  key_col,
    input  wire kmcm_mode_t  mode,
    output kmcm_char_t       char_code
);

    // columns past the matrix map to nothing
    always_comb begin
        char_code = '0;
        if (key_col < NUM_COLS) begin
            if (mode.symbol) begin
                char_code = MAP_SYMBOL[key_row][key_col];
            end else if (mode.upper) begin
                char_code = MAP_UPPER[key_row][key_col];
            end else begin
                char_code = MAP_LOWER[key_row][key_col];
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/key_matrix_to_char_mapper_top.sv
// key matrix to character mapper: entry buffer, modifiers and batch-end sequencer
//
// Input stream: one transaction per key entry. s_tuser[1:0] is the operation
// (press, release, end of batch), s_tdata holds the key row and column.
// Presses are buffered (up to MAX_PRESSED); symbol and shift presses set the
// modifier, their releases are held until the batch ends.
// Output stream: one transaction per mapped character, m_tlast on the final
// character of a batch. A batch with no characters produces no transaction.
// Press and release entries are accepted while the sequencer is idle. An
// end-of-batch entry keeps s_tready low while the sequencer reads one
// buffered key per cycle through the shared map lookup, waiting while the
// output is stalled, and then closes the batch in the flush state. One
// character is held back so the final one can carry m_tlast.
// When the receiver stalls the output register holds and the walk waits on it;
// input stays blocked until the batch is finished.
// Reset clears the buffer count, modifiers, caps lock and pending releases and
// arms caps lock; buffer contents are not cleared.
`default_nettype none

module key_matrix_to_char_mapper_top import kmcm_pkg::*; #(
    parameter int unsigned MAX_PRESSED = 8
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [1:0] key_row, [5:2] key_col, [7:6] zero
    input  wire logic [1:0] s_tuser,   // [1:0] operation
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [6:0] char_code, [7] zero
    output logic            m_tlast
);

    localparam int unsigned CNT_W = $clog2(MAX_PRESSED + 1);
    localparam int unsigned IDX_W = (MAX_PRESSED > 1) ? $clog2(MAX_PRESSED) : 1;

    kmcm_state_t      state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [NF_W-1:0]  nfound_reg, nfound_next;
    logic             symbol_reg, symbol_next;
    logic             shift_reg, shift_next;
    logic             caps_on_reg, caps_on_next;
    logic             caps_armed_reg, caps_armed_next;
    logic             sym_rel_reg, sym_rel_next;
    logic             shift_rel_reg, shift_rel_next;
    logic             hold_valid_reg, hold_valid_next;
    kmcm_char_t       hold_char_reg, hold_char_next;
    logic             out_valid_reg, out_valid_next;
    kmcm_char_t       out_char_reg, out_char_next;
    logic             out_last_reg, out_last_next;

    logic [5:0]       buf_mem [MAX_PRESSED];

    logic [1:0]       in_row;
    logic [3:0]       in_col;
    kmcm_op_t         in_op;
    logic             in_accept;
    logic             is_sym, is_shift;
    logic             buf_write;
    logic [5:0]       rd_entry;
    kmcm_mode_t       map_mode;
    kmcm_char_t       map_char;
    logic             out_free;
    logic             walk_done;

    assign in_row    = s_tdata[1:0];
    assign in_col    = s_tdata[5:2];
    assign in_op     = kmcm_op_t'(s_tuser);
    assign in_accept = s_tvalid && s_tready;
    assign is_sym    = (in_row == SYM_ROW) && (in_col == SYM_COL);
    assign is_shift  = (in_row == SHIFT_ROW) && (in_col == SHIFT_COL);
    assign buf_write = in_accept && (in_op == OP_PRESS) && (count_reg < CNT_W'(MAX_PRESSED));

    // pressed-key buffer
    always_ff @(posedge aclk) begin
        if (buf_write) begin
            buf_mem[count_reg[IDX_W-1:0]] <= {in_row, in_col};
        end
    end

    assign rd_entry = (idx_reg < count_reg) ? buf_mem[idx_reg[IDX_W-1:0]] : '0;

    // shared map lookup
    assign map_mode.symbol = symbol_reg;
    assign map_mode.upper  = shift_reg || caps_on_reg;

    kmcm_keymap u_keymap (
        .key_row   (rd_entry[5:4]),
        .key_col   (rd_entry[3:0]),
        .mode      (map_mode),
        .char_code (map_char)
    );

    assign out_free  = !out_valid_reg || m_tready;
    assign walk_done = (idx_reg == count_reg) || (nfound_reg == MAX_RESULTS);

    // sequencer: next state and register updates
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        nfound_next     = nfound_reg;
        symbol_next     = symbol_reg;
        shift_next      = shift_reg;
        caps_on_next    = caps_on_reg;
        caps_armed_next = caps_armed_reg;
        sym_rel_next    = sym_rel_reg;
        shift_rel_next  = shift_rel_reg;
        hold_valid_next = hold_valid_reg;
        hold_char_next  = hold_char_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_char_next   = out_char_reg;
        out_last_next   = out_last_reg;
        s_tready        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (in_accept) begin
                    case (in_op)
                        OP_PRESS: begin
                            if (is_sym) begin
                                symbol_next = 1'b1;
                            end
                            if (is_shift) begin
                                shift_next = 1'b1;
                            end
                            if (buf_write) begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_RELEASE: begin
                            if (is_sym) begin
                                sym_rel_next = 1'b1;
                            end
                            if (is_shift) begin
                                shift_rel_next = 1'b1;
                            end
                        end
                        OP_END: begin
                            // caps toggle comes before mapping
                            if (symbol_reg && shift_reg && caps_armed_reg) begin
                                caps_on_next    = !caps_on_reg;
                                caps_armed_next = 1'b0;
                            end
                            idx_next    = '0;
                            nfound_next = '0;
                            state_next  = ST_WALK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (walk_done) begin
                    state_next = ST_FLUSH;
                end else if (map_char != '0) begin
                    // a new character releases the held one as not last
                    if (!hold_valid_reg || out_free) begin
                        if (hold_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_char_next  = hold_char_reg;
                            out_last_next  = 1'b0;
                        end
                        hold_valid_next = 1'b1;
                        hold_char_next  = map_char;
                        nfound_next     = nfound_reg + NF_W'(1);
                        idx_next        = idx_reg + CNT_W'(1);
                    end
                end else begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_FLUSH: begin
                if (!hold_valid_reg || out_free) begin
                    if (hold_valid_reg) begin
                        out_valid_next = 1'b1;
                        out_char_next  = hold_char_reg;
                        out_last_next  = 1'b1;
                    end
                    hold_valid_next = 1'b0;
                    // apply releases, then re-arm caps
                    if (sym_rel_reg) begin
                        symbol_next = 1'b0;
                    end
                    if (shift_rel_reg) begin
                        shift_next = 1'b0;
                    end
                    if (!(symbol_reg && !sym_rel_reg) && !(shift_reg && !shift_rel_reg)) begin
                        caps_armed_next = 1'b1;
                    end
                    sym_rel_next   = 1'b0;
                    shift_rel_next = 1'b0;
                    count_next     = '0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            nfound_reg     <= '0;
            symbol_reg     <= 1'b0;
            shift_reg      <= 1'b0;
            caps_on_reg    <= 1'b0;
            caps_armed_reg <= 1'b1;
            sym_rel_reg    <= 1'b0;
            shift_rel_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            nfound_reg     <= nfound_next;
            symbol_reg     <= symbol_next;
            shift_reg      <= shift_next;
            caps_on_reg    <= caps_on_next;
            caps_armed_reg <= caps_armed_next;
            sym_rel_reg    <= sym_rel_next;
            shift_rel_reg  <= shift_rel_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        hold_char_reg <= hold_char_next;
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_char_reg};
    assign m_tlast  = out_last_reg;

    // checks
    `include "key_matrix_to_char_mapper_top_macros.svh"

    `KMCM_ASSERT_NOW(a_idle_no_held_char, state_reg == ST_IDLE, !hold_valid_reg, "held char while idle")
    `KMCM_ASSERT_NOW(a_result_cap, 1'b1, nfound_reg <= MAX_RESULTS, "result count over cap")
    `KMCM_ASSERT_NEXT(a_batch_clears, state_reg == ST_FLUSH && state_next == ST_IDLE, count_reg == '0 && !sym_rel_reg && !shift_rel_reg, "batch state not cleared")
    `KMCM_ASSERT_NEXT(a_caps_only_at_end, state_reg != ST_IDLE || !s_tvalid, $stable(caps_on_reg), "caps changed outside batch end")

endmodule

`default_nettype wire

FILE: test/key_matrix_to_char_mapper_top_tb.sv
// testbench for the key matrix to character mapper: batched key entries in, mapped characters out
`timescale 1ns / 100ps

module key_matrix_to_char_mapper_top_tb;
    import kmcm_pkg::*;

    localparam int KEY_DEPTH       = 8;
    localparam int PHASE_ENTRIES   = 115;
    localparam int LONG_HOLD       = 400;
    localparam int SETTLE_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // marks an empty slot in the key strings below
    localparam byte NO_CHAR = "~";

    typedef struct packed {
        kmcm_char_t code;
        logic       last;
    } char_exp_t;

    // tracks keyboard state and the characters each batch end must produce
    class char_tracker;
        bit [5:0]    key_buf [KEY_DEPTH];
        int unsigned key_count;
        bit          symbol_held, shift_held, caps_on, caps_armed;
        bit          symbol_rel, shift_rel;
        string       lower_rows [3];
        string       upper_rows [3];
        string       symbol_rows [3];
        char_exp_t   expected_chars [$];
        int unsigned errors;

        function new();
            key_count   = 0;
            symbol_held = 0;
            shift_held  = 0;
            caps_on     = 0;
            caps_armed  = 1;
            symbol_rel  = 0;
            shift_rel   = 0;
            errors      = 0;
            lower_rows  = '{"~qwertyuiop", "asdfghjkl\n~", "zxcvbnm~\010 ~"};
            upper_rows  = '{"~QWERTYUIOP", "ASDFGHJKL\n~", "ZXCVBNM~\010 ~"};
            symbol_rows = '{"~1234567890", "./+-=:'\"@\t~", "_$;?!,.~\010 ~"};
        endfunction

        // character for a key under the current modifiers, zero when none
        function kmcm_char_t map_key(bit [1:0] row, bit [3:0] col);
            string row_str;
            byte   code;
            if (col > 4'd10 || row == 2'd3) return '0;
            if (symbol_held) row_str = symbol_rows[row];
            else if (shift_held || caps_on) row_str = upper_rows[row];
            else row_str = lower_rows[row];
            code = row_str[col];
            return (code == NO_CHAR) ? '0 : code[6:0];
        endfunction

        function int unsigned outstanding();
            return expected_chars.size();
        endfunction

        // update state for one accepted input transaction
        function void note_entry(logic [1:0] op, logic [1:0] row, logic [3:0] col);
            bit         is_sym, is_shift;
            int unsigned i, n;
            kmcm_char_t code;
            char_exp_t  tail;
            is_sym   = (row == SYM_ROW) && (col == SYM_COL);
            is_shift = (row == SHIFT_ROW) && (col == SHIFT_COL);
            case (op)
                OP_PRESS: begin
                    if (is_sym) symbol_held = 1;
                    if (is_shift) shift_held = 1;
                    if (key_count < KEY_DEPTH) begin
                        key_buf[key_count] = {row, col};
                        key_count++;
                    end
                end
                OP_RELEASE: begin
                    if (is_sym) symbol_rel = 1;
                    if (is_shift) shift_rel = 1;
                end
                OP_END: begin
                    // caps lock toggles once per hold of both modifiers
                    if (symbol_held && shift_held && caps_armed) begin
                        caps_on    = !caps_on;
                        caps_armed = 0;
                    end
                    n = 0;
                    for (i = 0; i < key_count; i++) begin
                        code = map_key(key_buf[i][5:4], key_buf[i][3:0]);
                        if (code != '0 && n < MAX_RESULTS) begin
                            expected_chars.push_back(char_exp_t'{code: code, last: 1'b0});
                            n++;
                        end
                    end
                    if (n > 0) begin
                        tail = expected_chars.pop_back();
                        tail.last = 1'b1;
                        expected_chars.push_back(tail);
                    end
                    // releases land after the mapping
                    if (symbol_rel) symbol_held = 0;
                    if (shift_rel) shift_held = 0;
                    if (!symbol_held && !shift_held) caps_armed = 1;
                    symbol_rel = 0;
                    shift_rel  = 0;
                    key_count  = 0;
                end
                default: ;
            endcase
        endfunction

        // compare one output transaction with the oldest expected character
        function void check_result(logic [7:0] data, logic last);
            char_exp_t want;
            if (expected_chars.size() == 0) begin
                $error("unexpected result: char_code %0d last_char %0b", data[6:0], last);
                errors++;
                return;
            end
            want = expected_chars.pop_front();
            if (data[6:0] !== want.code) begin
                $error("char_code mismatch: expected %0d, actual %0d", want.code, data[6:0]);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_char mismatch: expected %0b, actual %0b", want.last, last);
                errors++;
            end
            if (data[7] !== 1'b0) begin
                $error("tdata pad mismatch: expected 0, actual %0b", data[7]);
                errors++;
            end
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = '0;    // [1:0] key_row, [5:2] key_col, [7:6] zero
    logic [1:0] s_tuser = '0;    // [1:0] operation
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;         // [6:0] char_code, [7] zero
    logic       m_tlast;

    char_tracker chars = new();
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_trig = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          entries_sent = 0;
    int          quiet_cycles = 0;

    key_matrix_to_char_mapper_top #(
        .MAX_PRESSED(KEY_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #1 aclk = ~aclk;

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge aclk) begin
        if (hold_trig != hold_seen) begin
            hold_seen = hold_trig;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) chars.check_result(m_tdata, m_tlast);
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one entry, with random idle cycles first, and wait for the transaction
    task automatic send_entry(input logic [1:0] op, input logic [1:0] row,
                              input logic [3:0] col);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, col, row};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        chars.note_entry(op, row, col);
        if (op != OP_UNUSED) entries_sent++;
    endtask

    // key choice weighted toward modifiers and mapped positions
    task automatic pick_key(input bit for_release, output logic [1:0] row,
                            output logic [3:0] col);
        int pick;
        pick = $urandom_range(99);
        if (pick < (for_release ? 40 : 12)) begin
            row = SYM_ROW;
            col = SYM_COL;
        end else if (pick < (for_release ? 80 : 24)) begin
            row = SHIFT_ROW;
            col = SHIFT_COL;
        end else if (pick < 88) begin
            row = 2'($urandom_range(2));
            col = 4'($urandom_range(10));
        end else begin
            row = 2'($urandom_range(3));
            col = 4'($urandom_range(15));
        end
    endtask

    // one scan batch with random content, sometimes malformed
    task automatic send_batch();
        int          n_press, n_rel, i;
        logic [1:0]  row;
        logic [3:0]  col;
        n_press = ($urandom_range(9) == 0) ? $urandom_range(9, 12) : $urandom_range(7);
        n_rel   = $urandom_range(2);
        for (i = 0; i < n_press; i++) begin
            pick_key(1'b0, row, col);
            send_entry(OP_PRESS, row, col);
            if ($urandom_range(29) == 0)
                send_entry(OP_UNUSED, 2'($urandom_range(3)), 4'($urandom_range(15)));
        end
        for (i = 0; i < n_rel; i++) begin
            pick_key(1'b1, row, col);
            send_entry(OP_RELEASE, row, col);
        end
        // out-of-order press after the releases
        if ($urandom_range(9) == 0) begin
            pick_key(1'b0, row, col);
            send_entry(OP_PRESS, row, col);
        end
        // occasionally the end marker is missing and batches merge
        if ($urandom_range(19) != 0)
            send_entry(OP_END, 2'($urandom_range(3)), 4'($urandom_range(15)));
    endtask

    // hold the sender until every expected character has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (chars.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int phase, target, i;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty batch, ignored code, empty and out-of-matrix keys, special characters
        send_entry(OP_END, 2'd0, 4'd0);
        send_entry(OP_UNUSED, 2'd3, 4'd15);
        send_entry(OP_PRESS, 2'd0, 4'd0);
        send_entry(OP_PRESS, 2'd3, 4'd15);
        send_entry(OP_PRESS, 2'd2, 4'd9);
        send_entry(OP_PRESS, 2'd2, 4'd8);
        send_entry(OP_PRESS, 2'd1, 4'd9);
        send_entry(OP_END, 2'd3, 4'd15);
        // shift alone gives upper case
        send_entry(OP_PRESS, SHIFT_ROW, SHIFT_COL);
        send_entry(OP_PRESS, 2'd1, 4'd0);
        send_entry(OP_RELEASE, SHIFT_ROW, SHIFT_COL);
        send_entry(OP_END, 2'd0, 4'd0);
        // symbol plus shift toggles caps lock, symbol map wins
        send_entry(OP_PRESS, SYM_ROW, SYM_COL);
        send_entry(OP_PRESS, SHIFT_ROW, SHIFT_COL);
        send_entry(OP_PRESS, 2'd0, 4'd1);
        send_entry(OP_END, 2'd0, 4'd0);
        // release and press of one modifier in a batch: release wins
        send_entry(OP_RELEASE, SYM_ROW, SYM_COL);
        send_entry(OP_RELEASE, SHIFT_ROW, SHIFT_COL);
        send_entry(OP_PRESS, SYM_ROW, SYM_COL);
        send_entry(OP_END, 2'd0, 4'd0);
        // full buffer, the symbol press past it still counts
        for (i = 1; i <= KEY_DEPTH; i++) send_entry(OP_PRESS, 2'd0, i[3:0]);
        send_entry(OP_PRESS, SYM_ROW, SYM_COL);
        send_entry(OP_END, 2'd0, 4'd0);
        send_entry(OP_RELEASE, SYM_ROW, SYM_COL);
        send_entry(OP_END, 2'd0, 4'd0);
        wait_drained();

        // random batches under the idling profiles
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 82; end
                default: begin send_idle_pct = 12; recv_stall_pct <= 12; end
            endcase
            // long receiver hold-off while the sender keeps going
            if (phase == 0) hold_trig <= hold_trig + 1;
            target = entries_sent + PHASE_ENTRIES;
            while (entries_sent < target) send_batch();
            wait_drained();
        end

        if (chars.errors == 0 && chars.outstanding() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
